/* rtl/byte_budget_history_ring_defines.svh */
// Assertion macros used by the checker file of the history ring
`ifndef BYTE_BUDGET_HISTORY_RING_DEFINES_SVH
`define BYTE_BUDGET_HISTORY_RING_DEFINES_SVH

// same-cycle implication, held off during reset
`define BBHR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define BBHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bbhr_pkg.sv */
// Types, constants and codes shared by the history ring modules
`default_nettype none

package bbhr_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = 6;
    localparam int BYTES_W = 32;
    localparam int TAG_W   = 16;
    localparam int TOTAL_W = 37;
    localparam int RANK_W  = 5;
    localparam int DELTA_W = 32;
    localparam int STEP_W  = $clog2(DELTA_W);
    localparam int OP_W    = 2;
    localparam int DEPTH_W = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_BYTE_BUDGET = 1'b1;

    localparam logic [DEPTH_W-1:0] ENTRY_LIMIT_RST = 8'd32;
    localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST = 32'd1048576;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_START = 2'd1,
        OP_CYCLE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PRE_CHK,
        ST_EV_RD,
        ST_EV_SUB,
        ST_WRITE,
        ST_POST_CHK,
        ST_DIV,
        ST_COMBINE,
        ST_MEM_RD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_PUSH,
        RES_MEM
    } t_res;

    typedef enum logic [1:0] {
        RD_OLDEST,
        RD_HEAD,
        RD_RANK,
        RD_BROWSE
    } t_rd_sel;

    typedef struct packed {
        logic [DEPTH_W-1:0] entry_limit;
        logic [BYTES_W-1:0] byte_budget;
    } t_cfg;

    typedef struct packed {
        logic    accept;
        logic    browse_end;
        logic    browse_start;
        logic    rd;
        t_rd_sel rd_sel;
        logic    evict;
        logic    push_write;
        logic    div_start;
        logic    div_step;
        logic    combine;
        logic    load_out;
        t_res    kind;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic count_zero;
        logic browse_live;
        logic rank_ok;
        logic depth_zero;
        logic at_depth;
        logic post_evict;
        logic div_last;
        logic out_hold;
    } t_status;

endpackage

`default_nettype wire

/* rtl/bbhr_regs.sv */
// Configuration register file behind the APB-style port
`default_nettype none

module bbhr_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbhr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bbhr_pkg::DATA_W-1:0] pwdata,
    output logic      [bbhr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output bbhr_pkg::t_cfg                   o_cfg
);
    import bbhr_pkg::*;

    logic [DEPTH_W-1:0] r_entry_limit;
    logic [BYTES_W-1:0] r_byte_budget;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= ENTRY_LIMIT_RST;
            r_byte_budget <= BYTE_BUDGET_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENTRY_LIMIT: r_entry_limit <= pwdata[DEPTH_W-1:0];
                REG_BYTE_BUDGET: r_byte_budget <= pwdata[BYTES_W-1:0];
                default:         r_entry_limit <= r_entry_limit;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENTRY_LIMIT: prdata = {{(DATA_W-DEPTH_W){1'b0}}, r_entry_limit};
            REG_BYTE_BUDGET: prdata = r_byte_budget;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.entry_limit = r_entry_limit;
    assign o_cfg.byte_budget = r_byte_budget;

endmodule

`default_nettype wire

/* rtl/bbhr_ctrl.sv */
// Sequencer that steps each item through the ring datapath
`default_nettype none

module bbhr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  bbhr_pkg::t_status      i_status,
    output bbhr_pkg::t_cmd         o_cmd
);
    import bbhr_pkg::*;

    t_state r_state, n_state;
    t_res   r_kind,  n_kind;
    logic   r_post,  n_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= RES_FAIL;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_post  <= n_post;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_post       = r_post;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_HEAD;
        o_cmd.kind   = r_kind;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.op)
                    OP_PUSH: begin
                        o_cmd.browse_end = 1'b1;
                        n_post           = 1'b0;
                        n_state          = ST_PRE_CHK;
                    end
                    OP_START: begin
                        if (!i_status.count_zero) begin
                            o_cmd.browse_start = 1'b1;
                            o_cmd.rd           = 1'b1;
                            o_cmd.rd_sel       = RD_HEAD;
                            n_kind             = RES_MEM;
                        end else begin
                            n_kind = RES_FAIL;
                        end
                        n_state = ST_DONE;
                    end
                    OP_CYCLE: begin
                        if (i_status.browse_live && !i_status.count_zero) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end else begin
                            n_kind  = RES_FAIL;
                            n_state = ST_DONE;
                        end
                    end
                    OP_READ: begin
                        if (i_status.rank_ok) begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = RD_RANK;
                            n_kind       = RES_MEM;
                        end else begin
                            n_kind = RES_FAIL;
                        end
                        n_state = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_PRE_CHK: begin
                priority if (i_status.depth_zero) begin
                    n_kind  = RES_FAIL;
                    n_state = ST_DONE;
                end else if (i_status.at_depth) begin
                    n_state = ST_EV_RD;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_EV_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = RD_OLDEST;
                n_state      = ST_EV_SUB;
            end
            ST_EV_SUB: begin
                o_cmd.evict = 1'b1;
                n_state     = r_post ? ST_POST_CHK : ST_PRE_CHK;
            end
            ST_WRITE: begin
                o_cmd.push_write = 1'b1;
                n_post           = 1'b1;
                n_state          = ST_POST_CHK;
            end
            ST_POST_CHK: begin
                if (i_status.post_evict) begin
                    n_state = ST_EV_RD;
                end else begin
                    n_kind  = RES_PUSH;
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_COMBINE;
                end
            end
            ST_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state       = ST_MEM_RD;
            end
            ST_MEM_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = RD_BROWSE;
                n_kind       = RES_MEM;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!i_status.out_hold) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bbhr_dp.sv */
// Ring datapath: slot memory, counters, byte total, rank divider, result register
`default_nettype none

module bbhr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  bbhr_pkg::t_cfg                     i_cfg,
    input  bbhr_pkg::t_cmd                     i_cmd,
    output bbhr_pkg::t_status                  o_status,
    input  wire logic [bbhr_pkg::OP_W-1:0]     i_op,
    input  wire logic [bbhr_pkg::BYTES_W-1:0]  i_entry_bytes,
    input  wire logic [bbhr_pkg::TAG_W-1:0]    i_entry_tag,
    input  wire logic signed [bbhr_pkg::DELTA_W-1:0] i_delta,
    input  wire logic [bbhr_pkg::RANK_W-1:0]   i_rank,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_ok,
    output logic      [bbhr_pkg::TAG_W-1:0]    o_out_tag,
    output logic      [bbhr_pkg::BYTES_W-1:0]  o_out_bytes,
    output logic      [bbhr_pkg::CNT_W-1:0]    o_entry_count,
    output logic      [bbhr_pkg::TOTAL_W-1:0]  o_held_bytes,
    output logic      [bbhr_pkg::CNT_W-1:0]    o_evicted,
    output logic      [bbhr_pkg::RANK_W-1:0]   o_out_rank
);
    import bbhr_pkg::*;

    // latched item
    t_op                        r_op;
    logic [BYTES_W-1:0]         r_eb;
    logic [TAG_W-1:0]           r_et;
    logic signed [DELTA_W-1:0]  r_delta;
    logic [RANK_W-1:0]          r_rk;

    // ring state
    logic [SLOT_W-1:0]          r_head;
    logic [CNT_W-1:0]           r_count;
    logic [TOTAL_W-1:0]         r_total;
    logic                       r_browse_live;
    logic [SLOT_W-1:0]          r_browse_slot;
    logic [CNT_W-1:0]           r_evicted;
    logic [RANK_W-1:0]          r_res_rank;

    // slot memory
    logic [BYTES_W-1:0]         r_slot_bytes [SLOTS];
    logic [TAG_W-1:0]           r_slot_tag   [SLOTS];
    logic [BYTES_W-1:0]         r_rd_bytes;
    logic [TAG_W-1:0]           r_rd_tag;

    // rank divider
    logic [CNT_W-1:0]           r_rem;
    logic [DELTA_W-1:0]         r_dvd;
    logic [STEP_W-1:0]          r_step;
    logic                       r_neg;
    logic [SLOT_W-1:0]          r_cur;

    // result register
    logic                       r_out_valid;
    logic                       r_o_ok;
    logic [TAG_W-1:0]           r_o_tag;
    logic [BYTES_W-1:0]         r_o_bytes;
    logic [CNT_W-1:0]           r_o_count;
    logic [TOTAL_W-1:0]         r_o_total;
    logic [CNT_W-1:0]           r_o_evicted;
    logic [RANK_W-1:0]          r_o_rank;

    logic [CNT_W-1:0]           depth_clamp;
    logic [SLOT_W-1:0]          oldest_slot;
    logic [SLOT_W-1:0]          rank_slot;
    logic [SLOT_W-1:0]          push_slot;
    logic [SLOT_W-1:0]          rd_addr;
    logic [SLOT_W-1:0]          cur_raw;
    logic [SLOT_W-1:0]          cur_start;
    logic [DELTA_W-1:0]         delta_u;
    logic [DELTA_W-1:0]         delta_mag;
    logic [CNT_W:0]             trial;
    logic [CNT_W:0]             trial_sub;
    logic [CNT_W:0]             comb_sum;
    logic [CNT_W:0]             comb_r;
    logic [SLOT_W-1:0]          new_rank;

    assign depth_clamp = (i_cfg.entry_limit > DEPTH_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                             : i_cfg.entry_limit[CNT_W-1:0];
    assign oldest_slot = r_head - r_count[SLOT_W-1:0] + SLOT_W'(1);
    assign rank_slot   = r_head - r_rk;
    assign push_slot   = (r_count == '0) ? r_head : r_head + SLOT_W'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_OLDEST: rd_addr = oldest_slot;
            RD_HEAD:   rd_addr = r_head;
            RD_RANK:   rd_addr = rank_slot;
            RD_BROWSE: rd_addr = r_browse_slot;
            default:   rd_addr = r_head;
        endcase
    end

    // starting rank of the browse pointer; a stale pointer restarts at the newest
    assign cur_raw   = r_head - r_browse_slot;
    assign cur_start = ({1'b0, cur_raw} >= r_count) ? '0 : cur_raw;
    assign delta_u   = r_delta;
    assign delta_mag = r_delta[DELTA_W-1] ? (~delta_u + DELTA_W'(1)) : delta_u;

    // one restoring step of |delta| mod count
    assign trial     = {r_rem, r_dvd[DELTA_W-1]};
    assign trial_sub = trial - {1'b0, r_count};

    // fold the remainder into the current rank
    always_comb begin
        comb_sum = '0;
        if (!r_neg) begin
            comb_sum = {2'b00, r_cur} + {1'b0, r_rem};
            comb_r   = (comb_sum >= {1'b0, r_count}) ? comb_sum - {1'b0, r_count}
                                                     : comb_sum;
        end else if ({2'b00, r_cur} >= {1'b0, r_rem}) begin
            comb_r = {2'b00, r_cur} - {1'b0, r_rem};
        end else begin
            comb_r = {2'b00, r_cur} + {1'b0, r_count} - {1'b0, r_rem};
        end
    end
    assign new_rank = comb_r[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_op);
            r_eb    <= i_entry_bytes;
            r_et    <= i_entry_tag;
            r_delta <= i_delta;
            r_rk    <= i_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_write) begin
            r_slot_bytes[push_slot] <= r_eb;
            r_slot_tag[push_slot]   <= r_et;
        end
        if (i_cmd.rd) begin
            r_rd_bytes <= r_slot_bytes[rd_addr];
            r_rd_tag   <= r_slot_tag[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_total       <= '0;
            r_browse_live <= 1'b0;
            r_browse_slot <= '0;
        end else begin
            if (i_cmd.push_write) begin
                r_head  <= push_slot;
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + TOTAL_W'(r_eb);
            end else if (i_cmd.evict) begin
                r_count <= r_count - CNT_W'(1);
                r_total <= r_total - TOTAL_W'(r_rd_bytes);
            end
            if (i_cmd.browse_end) begin
                r_browse_live <= 1'b0;
            end else if (i_cmd.browse_start) begin
                r_browse_live <= 1'b1;
                r_browse_slot <= r_head;
            end else if (i_cmd.combine) begin
                r_browse_slot <= r_head - new_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_evicted <= '0;
        end else if (i_cmd.evict) begin
            r_evicted <= r_evicted + CNT_W'(1);
        end
        if (i_cmd.browse_start) begin
            r_res_rank <= '0;
        end else if (i_cmd.combine) begin
            r_res_rank <= new_rank;
        end else if (i_cmd.rd && i_cmd.rd_sel == RD_RANK) begin
            r_res_rank <= r_rk;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dvd  <= delta_mag;
            r_step <= '0;
            r_neg  <= r_delta[DELTA_W-1];
            r_cur  <= cur_start;
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_sub[CNT_W] ? trial[CNT_W-1:0] : trial_sub[CNT_W-1:0];
            r_dvd  <= {r_dvd[DELTA_W-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_count   <= r_count;
            r_o_total   <= r_total;
            r_o_evicted <= r_evicted;
            unique case (i_cmd.kind)
                RES_PUSH: begin
                    r_o_ok    <= 1'b1;
                    r_o_tag   <= r_et;
                    r_o_bytes <= r_eb;
                    r_o_rank  <= '0;
                end
                RES_MEM: begin
                    r_o_ok    <= 1'b1;
                    r_o_tag   <= r_rd_tag;
                    r_o_bytes <= r_rd_bytes;
                    r_o_rank  <= r_res_rank;
                end
                default: begin
                    r_o_ok    <= 1'b0;
                    r_o_tag   <= '0;
                    r_o_bytes <= '0;
                    r_o_rank  <= '0;
                end
            endcase
        end
    end

    assign o_status.op          = r_op;
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.browse_live = r_browse_live;
    assign o_status.rank_ok     = ({1'b0, r_rk} < r_count);
    assign o_status.depth_zero  = (depth_clamp == '0);
    assign o_status.at_depth    = (r_count >= depth_clamp);
    assign o_status.post_evict  = (r_count > CNT_W'(1))
                                  && ((r_eb > i_cfg.byte_budget)
                                      || (r_total > TOTAL_W'(i_cfg.byte_budget)));
    assign o_status.div_last    = (r_step == STEP_W'(DELTA_W - 1));
    assign o_status.out_hold    = r_out_valid && i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_o_ok;
    assign o_out_tag     = r_o_tag;
    assign o_out_bytes   = r_o_bytes;
    assign o_entry_count = r_o_count;
    assign o_held_bytes  = r_o_total;
    assign o_evicted     = r_o_evicted;
    assign o_out_rank    = r_o_rank;

endmodule

`default_nettype wire

/* rtl/byte_budget_history_ring.sv */
// Push runs dispatch, depth check (refused at depth zero), write, budget check, and a read and a
// subtract per evicted entry. Start browse and read rank read the slot in dispatch. Cycle browse
// runs the one-bit-a-step remainder, folds it into the rank and reads the slot. One item at a
// time; the next is taken once the result is registered, a stalled result holds the sequencer.
// Reset (synchronous, active low) empties the ring, ends browse, restores the registers.
// Top level of the byte-budgeted history ring
`default_nettype none

module byte_budget_history_ring (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bbhr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bbhr_pkg::DATA_W-1:0]   pwdata,
    output logic      [bbhr_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bbhr_pkg::OP_W-1:0]     i_op,
    input  wire logic [bbhr_pkg::BYTES_W-1:0]  i_entry_bytes,
    input  wire logic [bbhr_pkg::TAG_W-1:0]    i_entry_tag,
    input  wire logic signed [bbhr_pkg::DELTA_W-1:0] i_delta,
    input  wire logic [bbhr_pkg::RANK_W-1:0]   i_rank,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_ok,
    output logic      [bbhr_pkg::TAG_W-1:0]    o_out_tag,
    output logic      [bbhr_pkg::BYTES_W-1:0]  o_out_bytes,
    output logic      [bbhr_pkg::CNT_W-1:0]    o_entry_count,
    output logic      [bbhr_pkg::TOTAL_W-1:0]  o_held_bytes,
    output logic      [bbhr_pkg::CNT_W-1:0]    o_evicted,
    output logic      [bbhr_pkg::RANK_W-1:0]   o_out_rank
);
    import bbhr_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    bbhr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbhr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bbhr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_op),
        .i_entry_bytes (i_entry_bytes),
        .i_entry_tag   (i_entry_tag),
        .i_delta       (i_delta),
        .i_rank        (i_rank),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_out_tag     (o_out_tag),
        .o_out_bytes   (o_out_bytes),
        .o_entry_count (o_entry_count),
        .o_held_bytes  (o_held_bytes),
        .o_evicted     (o_evicted),
        .o_out_rank    (o_out_rank)
    );

endmodule

`default_nettype wire

/* rtl/bbhr_checker.sv */
// Port-level checks on the history ring results, bound to the top level
`default_nettype none

`include "byte_budget_history_ring_defines.svh"

module bbhr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic                          o_ok,
    input wire logic [bbhr_pkg::TAG_W-1:0]    o_out_tag,
    input wire logic [bbhr_pkg::BYTES_W-1:0]  o_out_bytes,
    input wire logic [bbhr_pkg::CNT_W-1:0]    o_entry_count,
    input wire logic [bbhr_pkg::CNT_W-1:0]    o_evicted,
    input wire logic [bbhr_pkg::RANK_W-1:0]   o_out_rank
);
    import bbhr_pkg::*;

    // a stalled result stays up
    `BBHR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    // a refused item carries no entry
    `BBHR_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_ok, (o_out_tag == '0) && (o_out_bytes == '0) && (o_out_rank == '0))
    // the ring never holds more than its slots
    `BBHR_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, o_out_valid, o_entry_count <= CNT_W'(SLOTS))
    // evictions only come with a stored entry
    `BBHR_ASSERT_IMPL(a_evict_ok, i_clk, i_rst_n, o_out_valid && (o_evicted != '0), o_ok && (o_entry_count != '0))

endmodule

bind byte_budget_history_ring bbhr_checker u_bbhr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_ok          (o_ok),
    .o_out_tag     (o_out_tag),
    .o_out_bytes   (o_out_bytes),
    .o_entry_count (o_entry_count),
    .o_evicted     (o_evicted),
    .o_out_rank    (o_out_rank)
);

`default_nettype wire
